// ===== sv/i2cm_pkg.sv =====
// types and constants of the i2c master register block
// no dependencies
package i2cm_pkg;

    typedef struct packed {
        logic        mode;
        logic [11:0] offset;
        logic [3:0]  access_size;
        logic [31:0] wdata;
        logic        addr_ack;
        logic        data_ack;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq_line;
        logic        stop_before;
        logic        start_issued;
        logic [6:0]  start_address;
        logic        start_read;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        recv_issued;
        logic        stop_after;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic out_load;
    } t_cmd;

    localparam logic [31:0] C_CON_RESET  = 32'h65;
    localparam logic [31:0] C_SAR_RESET  = 32'h55;
    localparam logic [31:0] C_HOLD_RESET = 32'h10000;
    localparam logic [31:0] C_COMP_VER   = 32'h3131312a;
    localparam logic [31:0] C_COMP_TYPE  = 32'h44570140;
    localparam logic [31:0] C_EMPTY_READ = 32'hff;

    localparam int W_CON       = 0;
    localparam int W_TAR       = 1;
    localparam int W_SAR       = 2;
    localparam int W_INTR_MASK = 12;
    localparam int W_RAW       = 13;
    localparam int W_ENABLE    = 27;
    localparam int W_HOLD      = 31;
    localparam int W_ABRT_SRC  = 32;

    localparam logic [31:0] I_RX_UNDER  = 32'h1;
    localparam logic [31:0] I_RX_OVER   = 32'h2;
    localparam logic [31:0] I_RX_FULL   = 32'h4;
    localparam logic [31:0] I_TX_EMPTY  = 32'h10;
    localparam logic [31:0] I_TX_ABRT   = 32'h40;
    localparam logic [31:0] I_ACTIVITY  = 32'h100;
    localparam logic [31:0] I_STOP_DET  = 32'h200;
    localparam logic [31:0] I_START_DET = 32'h400;

    localparam logic [31:0] ABRT_DISABLED = 32'h800;
    localparam logic [31:0] ABRT_ADDR_NAK = 32'h1;
    localparam logic [31:0] ABRT_DATA_NAK = 32'h8;

    localparam logic [11:0] OFF_CMD      = 12'h10;
    localparam logic [11:0] OFF_INTR     = 12'h2c;
    localparam logic [11:0] OFF_RAW      = 12'h34;
    localparam logic [11:0] OFF_RX_TL    = 12'h38;
    localparam logic [11:0] OFF_TX_TL    = 12'h3c;
    localparam logic [11:0] OFF_CLR_ALL  = 12'h40;
    localparam logic [11:0] OFF_CLR_UND  = 12'h44;
    localparam logic [11:0] OFF_CLR_OVR  = 12'h48;
    localparam logic [11:0] OFF_CLR_4C   = 12'h4c;
    localparam logic [11:0] OFF_CLR_50   = 12'h50;
    localparam logic [11:0] OFF_CLR_ABRT = 12'h54;
    localparam logic [11:0] OFF_CLR_58   = 12'h58;
    localparam logic [11:0] OFF_CLR_ACT  = 12'h5c;
    localparam logic [11:0] OFF_CLR_STOP = 12'h60;
    localparam logic [11:0] OFF_CLR_STRT = 12'h64;
    localparam logic [11:0] OFF_CLR_68   = 12'h68;
    localparam logic [11:0] OFF_ENABLE   = 12'h6c;
    localparam logic [11:0] OFF_STATUS   = 12'h70;
    localparam logic [11:0] OFF_TXFLR    = 12'h74;
    localparam logic [11:0] OFF_RXFLR    = 12'h78;
    localparam logic [11:0] OFF_EN_STAT  = 12'h9c;
    localparam logic [11:0] OFF_START    = 12'ha0;
    localparam logic [11:0] OFF_CLR_A8   = 12'ha8;
    localparam logic [11:0] OFF_PARAM    = 12'hf4;
    localparam logic [11:0] OFF_COMP_VER = 12'hf8;
    localparam logic [11:0] OFF_COMP_TYP = 12'hfc;

endpackage

// ===== sv/i2cm_ctrl.sv =====
// controller: sequences one register access through the datapath
// depends on i2cm_pkg
module i2cm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic          i_init_done,
    output i2cm_pkg::t_cmd o_cmd
);
    import i2cm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid && i_init_done) n_state = ST_READ;
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: n_state = ST_OUT;
            ST_OUT:  if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == ST_IDLE) && i_init_done;
        o_cmd.load    = (r_state == ST_IDLE) && i_init_done && i_in_valid;
        o_cmd.exec    = (r_state == ST_EXEC);
        o_cmd.out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
        n_out_valid   = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_exec_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |=> o_cmd.exec) else $error("exec did not follow read");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_in_ready) else $error("ready while busy");
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready)) else $error("result overwritten");
endmodule

// ===== sv/i2cm_dp.sv =====
// datapath: register file memory, receive fifo and transfer state
// depends on i2cm_pkg
module i2cm_dp #(
    parameter int RX_DEPTH  = 16,
    parameter int REG_WORDS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cm_pkg::t_cmd      i_cmd,
    input  i2cm_pkg::t_in_item  i_item,
    output i2cm_pkg::t_out_item o_item,
    output logic                o_init_done
);
    import i2cm_pkg::*;

    localparam int WA = $clog2(REG_WORDS);
    localparam int RA = $clog2(RX_DEPTH);
    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam logic [31:0] SAT = 32'(RX_DEPTH - 1);

    // memory holds the plain words; the few words with side effects live in flops
    logic [31:0] r_mem [REG_WORDS];
    logic [31:0] r_mem_q;
    logic [7:0]  r_rx [RX_DEPTH];
    logic [7:0]  r_rx_q;

    t_in_item    r_in;
    logic [31:0] r_con, r_tar, r_sar, r_mask, r_raw, r_hold, r_abrt;
    logic [31:0] r_en;
    logic [RA-1:0] r_head;
    logic [CW-1:0] r_count;
    logic        r_active, r_dir;
    logic [6:0]  r_target;
    t_out_item   r_res, r_out;
    logic        r_init_done;
    logic [WA-1:0] r_clr_idx;

    logic [31:0] n_con, n_tar, n_sar, n_mask, n_raw, n_hold, n_abrt;
    logic [31:0] n_en;
    logic [RA-1:0] n_head;
    logic [CW-1:0] n_count;
    logic        n_active, n_dir;
    logic [6:0]  n_target;
    t_out_item   n_res;
    logic        mem_we, rx_we;
    logic [31:0] mem_wd;
    logic [RA-1:0] rx_wa;

    logic        good;
    logic [WA-1:0] w;
    logic [31:0] raw_now;
    logic [31:0] v;
    logic        rd, stp, rst;
    logic [6:0]  tgt;
    logic [RA:0] pos;
    logic        keep;

    assign good = ({20'b0, r_in.offset} < 32'(REG_WORDS * 4)) && (r_in.access_size == 4'd4);
    assign w    = r_in.offset[WA+1:2];
    assign v    = r_in.wdata;

    // memory and fifo reads registered in the read state
    always_ff @(posedge i_clk) begin
        r_mem_q <= r_mem[w];
        r_rx_q  <= r_rx[r_head];
        if (!r_init_done) r_mem[r_clr_idx] <= '0;
        else if (mem_we && i_cmd.exec) r_mem[w] <= mem_wd;
        if (rx_we && i_cmd.exec) r_rx[rx_wa] <= r_in.rx_byte;
    end

    function automatic logic [31:0] f_raw(input logic [31:0] raw, input logic en,
                                          input logic nz, input logic act);
        logic [31:0] r;
        r = raw;
        if (en) r = r | I_TX_EMPTY;
        r = nz ? (r | I_RX_FULL) : (r & ~I_RX_FULL);
        r = act ? (r | I_ACTIVITY) : (r & ~I_ACTIVITY);
        return r;
    endfunction

    assign raw_now = f_raw(r_raw, r_en[0], r_count != '0, r_active);

    always_comb begin
        n_con = r_con; n_tar = r_tar; n_sar = r_sar; n_mask = r_mask; n_raw = r_raw;
        n_hold = r_hold; n_abrt = r_abrt; n_en = r_en; n_head = r_head; n_count = r_count;
        n_active = r_active; n_dir = r_dir; n_target = r_target;
        n_res = '0;
        mem_we = 1'b0; mem_wd = v; rx_we = 1'b0; rx_wa = '0;
        rd = v[8]; stp = v[9]; rst = v[10]; tgt = r_tar[6:0];
        pos = '0; keep = 1'b0;
        if (good && r_in.mode) begin
            case (r_in.offset)
                OFF_CMD: begin
                    if (!r_en[0]) begin
                        n_abrt = ABRT_DISABLED;
                        if (r_active) begin n_active = 1'b0; n_res.stop_after = 1'b1; end
                        n_raw = n_raw | I_TX_ABRT | I_STOP_DET;
                    end else begin
                        keep = r_active && !rst && (r_dir == rd) && (r_target == tgt);
                        if (!keep) begin
                            n_res.stop_before = r_active;
                            n_active = 1'b0;
                            n_res.start_issued = 1'b1;
                            n_res.start_address = tgt;
                            n_res.start_read = rd;
                        end
                        if (!keep && !r_in.addr_ack) begin
                            n_abrt = ABRT_ADDR_NAK;
                            n_raw = n_raw | I_TX_ABRT | I_STOP_DET;
                        end else begin
                            if (!keep) begin
                                n_active = 1'b1; n_dir = rd; n_target = tgt;
                                n_raw = n_raw | I_START_DET;
                            end
                            if (rd) begin
                                n_res.recv_issued = 1'b1;
                                if ({1'b0, r_count} >= (CW+1)'(RX_DEPTH)) begin
                                    n_raw = n_raw | I_RX_OVER;
                                end else begin
                                    pos = (RA+1)'(r_head) + (RA+1)'(r_count);
                                    if (pos >= (RA+1)'(RX_DEPTH)) pos = pos - (RA+1)'(RX_DEPTH);
                                    rx_we = 1'b1; rx_wa = pos[RA-1:0];
                                    n_count = r_count + 1'b1;
                                end
                            end else begin
                                n_res.send_valid = 1'b1;
                                n_res.send_byte = v[7:0];
                            end
                            if (!rd && !r_in.data_ack) begin
                                n_abrt = ABRT_DATA_NAK;
                                n_active = 1'b0;
                                n_res.stop_after = 1'b1;
                                n_raw = n_raw | I_TX_ABRT | I_STOP_DET;
                            end else if (stp) begin
                                if (n_active) n_res.stop_after = 1'b1;
                                n_active = 1'b0;
                                n_raw = n_raw | I_STOP_DET;
                            end
                        end
                    end
                end
                OFF_ENABLE: begin
                    n_en = {31'b0, v[0]};
                    if (!v[0]) begin
                        if (r_active) begin n_active = 1'b0; n_res.stop_after = 1'b1; end
                        n_head = '0; n_count = '0;
                    end
                end
                OFF_RX_TL, OFF_TX_TL: begin
                    mem_we = 1'b1;
                    mem_wd = (v > SAT) ? SAT : v;
                end
                OFF_START: if (v[0]) n_en = 32'd1;
                default: begin
                    case (32'(w))
                        W_CON:       n_con = v;
                        W_TAR:       n_tar = v;
                        W_SAR:       n_sar = v;
                        W_INTR_MASK: n_mask = v;
                        W_RAW:       n_raw = v;
                        W_ENABLE:    n_en = v;
                        W_HOLD:      n_hold = v;
                        W_ABRT_SRC:  n_abrt = v;
                        default:     mem_we = 1'b1;
                    endcase
                end
            endcase
        end else if (good) begin
            case (r_in.offset)
                OFF_CMD: begin
                    if (r_count == '0) begin
                        n_raw = n_raw | I_RX_UNDER;
                        n_res.rdata = C_EMPTY_READ;
                    end else begin
                        n_res.rdata = {24'b0, r_rx_q};
                        n_head = (32'(r_head) + 1 >= RX_DEPTH) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
                OFF_INTR:     n_res.rdata = raw_now & r_mask;
                OFF_RAW:      n_res.rdata = raw_now;
                OFF_CLR_ALL:  begin n_raw = r_raw & I_RX_FULL; n_res.rdata = 32'd1; end
                OFF_CLR_UND:  begin n_raw = r_raw & ~32'h1; n_res.rdata = 32'd1; end
                OFF_CLR_OVR:  begin n_raw = r_raw & ~32'h2; n_res.rdata = 32'd1; end
                OFF_CLR_4C:   begin n_raw = r_raw & ~32'h8; n_res.rdata = 32'd1; end
                OFF_CLR_50:   begin n_raw = r_raw & ~32'h20; n_res.rdata = 32'd1; end
                OFF_CLR_ABRT: begin
                    n_raw = r_raw & ~32'h40; n_abrt = '0; n_res.rdata = 32'd1;
                end
                OFF_CLR_58:   begin n_raw = r_raw & ~32'h80; n_res.rdata = 32'd1; end
                OFF_CLR_ACT:  begin n_raw = r_raw & ~32'h100; n_res.rdata = 32'd1; end
                OFF_CLR_STOP: begin n_raw = r_raw & ~32'h200; n_res.rdata = 32'd1; end
                OFF_CLR_STRT: begin n_raw = r_raw & ~32'h400; n_res.rdata = 32'd1; end
                OFF_CLR_68:   begin n_raw = r_raw & ~32'h800; n_res.rdata = 32'd1; end
                OFF_CLR_A8:   begin n_raw = r_raw & ~32'h1000; n_res.rdata = 32'd1; end
                OFF_EN_STAT:  n_res.rdata = {31'b0, r_en[0]};
                OFF_STATUS:   n_res.rdata = 32'h6 | ((r_count != '0) ? 32'h8 : 32'h0)
                                          | (r_active ? 32'h21 : 32'h0);
                OFF_TXFLR:    n_res.rdata = '0;
                OFF_RXFLR:    n_res.rdata = 32'(r_count);
                OFF_PARAM:    n_res.rdata = (SAT << 16) | (SAT << 8) | 32'hc;
                OFF_COMP_VER: n_res.rdata = C_COMP_VER;
                OFF_COMP_TYP: n_res.rdata = C_COMP_TYPE;
                default: begin
                    case (32'(w))
                        W_CON:       n_res.rdata = r_con;
                        W_TAR:       n_res.rdata = r_tar;
                        W_SAR:       n_res.rdata = r_sar;
                        W_INTR_MASK: n_res.rdata = r_mask;
                        W_RAW:       n_res.rdata = r_raw;
                        W_ENABLE:    n_res.rdata = r_en;
                        W_HOLD:      n_res.rdata = r_hold;
                        W_ABRT_SRC:  n_res.rdata = r_abrt;
                        default:     n_res.rdata = r_mem_q;
                    endcase
                end
            endcase
        end
        n_res.irq_line = (f_raw(n_raw, n_en[0], n_count != '0, n_active) & n_mask) != '0;
    end

    // plain memory words must read zero until written: clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_done <= 1'b0;
            r_clr_idx   <= '0;
        end else if (!r_init_done) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == WA'(REG_WORDS - 1)) r_init_done <= 1'b1;
        end
    end

    assign o_init_done = r_init_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_item;
        if (i_cmd.exec) r_res <= n_res;
        if (i_cmd.out_load) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_con <= C_CON_RESET; r_tar <= '0; r_sar <= C_SAR_RESET; r_mask <= '0;
            r_raw <= '0; r_hold <= C_HOLD_RESET; r_abrt <= '0; r_en <= '0;
            r_head <= '0; r_count <= '0; r_active <= 1'b0; r_dir <= 1'b0; r_target <= '0;
        end else if (i_cmd.exec) begin
            r_con <= n_con; r_tar <= n_tar; r_sar <= n_sar; r_mask <= n_mask;
            r_raw <= n_raw; r_hold <= n_hold; r_abrt <= n_abrt; r_en <= n_en;
            r_head <= n_head; r_count <= n_count; r_active <= n_active;
            r_dir <= n_dir; r_target <= n_target;
        end
    end

    assign o_item = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= RX_DEPTH) else $error("fifo count beyond depth");
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_head) < RX_DEPTH) else $error("fifo head beyond depth");
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count) && $stable(r_active))
        else $error("state changed outside exec");
endmodule

// ===== sv/i2c_master_register_block_unit.sv =====
// top level of the i2c master register block
// depends on i2cm_pkg, i2cm_ctrl, i2cm_dp
//
// channel | direction | payload            | handshake
// in      | input     | i2cm_pkg::t_in_item  | i_in_valid / o_in_ready
// out     | output    | i2cm_pkg::t_out_item | o_out_valid / i_out_ready
//
// one access steps through accept, memory read, execute and result load
// a new access is taken only after the previous result has been loaded
// the result register holds while the output is stalled
// synchronous active-low reset; plain register words are cleared by a
// pass over all REG_WORDS words after reset, input not ready until it ends
module i2c_master_register_block_unit #(
    parameter int RX_DEPTH  = 16,
    parameter int REG_WORDS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  i2cm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output i2cm_pkg::t_out_item o_out_data
);
    import i2cm_pkg::*;

    t_cmd cmd;
    logic init_done;

    i2cm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_init_done(init_done),
        .o_cmd(cmd)
    );

    i2cm_dp #(.RX_DEPTH(RX_DEPTH), .REG_WORDS(REG_WORDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .i_item(i_in_data), .o_item(o_out_data),
        .o_init_done(init_done)
    );
endmodule

// ===== tb/tb_top.sv =====
// testbench for the i2c master register block: random and directed register accesses
// depends on i2cm_pkg and i2c_master_register_block_unit; checks every result in order
`timescale 1ns / 100ps

module tb_top;
    import i2cm_pkg::*;

    localparam int DEPTH = 16;
    localparam int WORDS = 64;

    // behavioral copy of the block, predicts one result per access
    class access_scoreboard;
        logic [31:0] regs [WORDS];
        logic [7:0]  rx_mem [DEPTH];
        int unsigned rx_head;
        int unsigned rx_count;
        bit          busy;
        bit          cur_rd;
        logic [6:0]  cur_tgt;
        t_out_item   pending [$];
        int          errors;

        function void clear();
            foreach (regs[k]) regs[k] = '0;
            foreach (rx_mem[k]) rx_mem[k] = '0;
            regs[W_CON]  = C_CON_RESET;
            regs[W_SAR]  = C_SAR_RESET;
            regs[W_HOLD] = C_HOLD_RESET;
            rx_head = 0;
            rx_count = 0;
            busy = 0;
            cur_rd = 0;
            cur_tgt = '0;
            errors = 0;
        endfunction

        function logic [31:0] raw();
            logic [31:0] r;
            r = regs[W_RAW];
            if (regs[W_ENABLE][0]) r |= I_TX_EMPTY;
            if (rx_count != 0) r |= I_RX_FULL; else r &= ~I_RX_FULL;
            if (busy) r |= I_ACTIVITY; else r &= ~I_ACTIVITY;
            return r;
        endfunction

        function void finish_xfer(inout t_out_item o);
            if (busy) begin
                busy = 0;
                o.stop_after = 1;
            end
        endfunction

        function void abort_xfer(logic [31:0] src, inout t_out_item o);
            regs[W_ABRT_SRC] = src;
            finish_xfer(o);
            regs[W_RAW] |= I_TX_ABRT | I_STOP_DET;
        endfunction

        function void run_command(t_in_item a, inout t_out_item o);
            bit rd, stp, rst;
            logic [6:0] tgt;
            rd = a.wdata[8];
            stp = a.wdata[9];
            rst = a.wdata[10];
            tgt = regs[W_TAR][6:0];
            if (!regs[W_ENABLE][0]) begin
                abort_xfer(ABRT_DISABLED, o);
                return;
            end
            if (!(busy && !rst && cur_rd == rd && cur_tgt == tgt)) begin
                if (busy) begin
                    busy = 0;
                    o.stop_before = 1;
                end
                o.start_issued = 1;
                o.start_address = tgt;
                o.start_read = rd;
                if (!a.addr_ack) begin
                    abort_xfer(ABRT_ADDR_NAK, o);
                    return;
                end
                busy = 1;
                cur_rd = rd;
                cur_tgt = tgt;
                regs[W_RAW] |= I_START_DET;
            end
            if (rd) begin
                o.recv_issued = 1;
                if (rx_count >= DEPTH) regs[W_RAW] |= I_RX_OVER;
                else begin
                    rx_mem[(rx_head + rx_count) % DEPTH] = a.rx_byte;
                    rx_count++;
                end
            end else begin
                o.send_valid = 1;
                o.send_byte = a.wdata[7:0];
                if (!a.data_ack) begin
                    abort_xfer(ABRT_DATA_NAK, o);
                    return;
                end
            end
            if (stp) begin
                finish_xfer(o);
                regs[W_RAW] |= I_STOP_DET;
            end
        endfunction

        function logic [31:0] read_reg(logic [11:0] off);
            logic [31:0] v;
            case (off)
                OFF_CMD: begin
                    if (rx_count == 0) begin
                        regs[W_RAW] |= I_RX_UNDER;
                        return C_EMPTY_READ;
                    end
                    v = {24'h0, rx_mem[rx_head]};
                    rx_head = (rx_head + 1) % DEPTH;
                    rx_count--;
                    return v;
                end
                OFF_INTR:     return raw() & regs[W_INTR_MASK];
                OFF_RAW:      return raw();
                OFF_CLR_ALL:  begin regs[W_RAW] &= I_RX_FULL; return 1; end
                OFF_CLR_UND:  begin regs[W_RAW] &= ~32'h1; return 1; end
                OFF_CLR_OVR:  begin regs[W_RAW] &= ~32'h2; return 1; end
                OFF_CLR_4C:   begin regs[W_RAW] &= ~32'h8; return 1; end
                OFF_CLR_50:   begin regs[W_RAW] &= ~32'h20; return 1; end
                OFF_CLR_ABRT: begin
                    regs[W_RAW] &= ~32'h40;
                    regs[W_ABRT_SRC] = '0;
                    return 1;
                end
                OFF_CLR_58:   begin regs[W_RAW] &= ~32'h80; return 1; end
                OFF_CLR_ACT:  begin regs[W_RAW] &= ~32'h100; return 1; end
                OFF_CLR_STOP: begin regs[W_RAW] &= ~32'h200; return 1; end
                OFF_CLR_STRT: begin regs[W_RAW] &= ~32'h400; return 1; end
                OFF_CLR_68:   begin regs[W_RAW] &= ~32'h800; return 1; end
                OFF_CLR_A8:   begin regs[W_RAW] &= ~32'h1000; return 1; end
                OFF_EN_STAT:  return {31'h0, regs[W_ENABLE][0]};
                OFF_STATUS:   return 32'h6 | (rx_count != 0 ? 32'h8 : 0) | (busy ? 32'h21 : 0);
                OFF_TXFLR:    return '0;
                OFF_RXFLR:    return rx_count;
                OFF_PARAM:    return ((DEPTH - 1) << 16) | ((DEPTH - 1) << 8) | 32'hc;
                OFF_COMP_VER: return C_COMP_VER;
                OFF_COMP_TYP: return C_COMP_TYPE;
                default:      return regs[off[7:2]];
            endcase
        endfunction

        function void write_reg(t_in_item a, inout t_out_item o);
            case (a.offset)
                OFF_CMD: run_command(a, o);
                OFF_ENABLE: begin
                    regs[W_ENABLE] = {31'h0, a.wdata[0]};
                    if (!a.wdata[0]) begin
                        finish_xfer(o);
                        rx_head = 0;
                        rx_count = 0;
                    end
                end
                OFF_RX_TL, OFF_TX_TL:
                    regs[a.offset[7:2]] = (a.wdata > DEPTH - 1) ? DEPTH - 1 : a.wdata;
                OFF_START: if (a.wdata[0]) regs[W_ENABLE] = 1;
                default: regs[a.offset[7:2]] = a.wdata;
            endcase
        endfunction

        function void note_access(t_in_item a);
            t_out_item o;
            o = '0;
            if (a.offset < WORDS * 4 && a.access_size == 4) begin
                if (a.mode) write_reg(a, o);
                else o.rdata = read_reg(a.offset);
            end
            o.irq_line = (raw() & regs[W_INTR_MASK]) != 0;
            pending.push_back(o);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.rdata !== exp.rdata)
                $display("%0t: rdata exp %h got %h", $time, exp.rdata, got.rdata);
            if (got.irq_line !== exp.irq_line)
                $display("%0t: irq_line exp %b got %b", $time, exp.irq_line, got.irq_line);
            if (got.stop_before !== exp.stop_before)
                $display("%0t: stop_before exp %b got %b", $time, exp.stop_before,
                         got.stop_before);
            if (got.start_issued !== exp.start_issued)
                $display("%0t: start_issued exp %b got %b", $time, exp.start_issued,
                         got.start_issued);
            if (got.start_address !== exp.start_address)
                $display("%0t: start_address exp %h got %h", $time, exp.start_address,
                         got.start_address);
            if (got.start_read !== exp.start_read)
                $display("%0t: start_read exp %b got %b", $time, exp.start_read,
                         got.start_read);
            if (got.send_valid !== exp.send_valid)
                $display("%0t: send_valid exp %b got %b", $time, exp.send_valid,
                         got.send_valid);
            if (got.send_byte !== exp.send_byte)
                $display("%0t: send_byte exp %h got %h", $time, exp.send_byte, got.send_byte);
            if (got.recv_issued !== exp.recv_issued)
                $display("%0t: recv_issued exp %b got %b", $time, exp.recv_issued,
                         got.recv_issued);
            if (got.stop_after !== exp.stop_after)
                $display("%0t: stop_after exp %b got %b", $time, exp.stop_after,
                         got.stop_after);
            if (got !== exp) errors++;
        endfunction
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 0;
    t_out_item o_out_data;
    bit        sink_on = 0;

    access_scoreboard board;

    always #4 i_clk = ~i_clk;

    i2c_master_register_block_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    task automatic send_access(bit wr, logic [11:0] off, logic [31:0] data,
                               bit aack = 1, bit dack = 1, logic [7:0] rxb = 8'h00,
                               logic [3:0] sz = 4);
        t_in_item a;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        a.mode = wr;
        a.offset = off;
        a.access_size = sz;
        a.wdata = data;
        a.addr_ack = aack;
        a.data_ack = dack;
        a.rx_byte = rxb;
        i_in_data <= a;
        i_in_valid <= 1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_access(a);
    endtask

    // result side with random stalls, sampled on the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n && sink_on) begin
            if (o_out_valid && i_out_ready) board.check_result(o_out_data);
            i_out_ready <= ($urandom_range(0, 3) == 0) || ($urandom_range(0, 1) == 0);
        end
    end

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [11:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return OFF_CMD;
        if (r < 40) return 12'h04;
        if (r < 45) return OFF_ENABLE;
        if (r < 85) return {4'h0, 6'($urandom_range(0, 63)), 2'b00};
        if (r < 92) return 12'($urandom_range(0, 255));
        return 12'($urandom_range(0, 4095));
    endfunction

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_in_item r;
        board = new();
        board.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        sink_on = 1;
        // directed: disabled command, enable, naks, fifo over and under, constants
        send_access(1, OFF_CMD, 32'h0000_0112);
        send_access(1, OFF_START, 32'h1);
        send_access(1, 12'h04, 32'h7f);
        send_access(1, 12'h30, 32'hffff_ffff);
        send_access(1, OFF_CMD, 32'h0000_00ff, 0);
        send_access(1, OFF_CMD, 32'h0000_00a5, 1, 0);
        send_access(1, OFF_CMD, 32'h0000_0000, 1, 1);
        for (int k = 0; k < DEPTH + 2; k++)
            send_access(1, OFF_CMD, 32'h0000_0100, 1, 1, 8'(255 - k));
        send_access(0, OFF_RAW, 0);
        send_access(1, OFF_CMD, 32'h0000_0700, 1, 1, 8'h00);
        send_access(1, OFF_RX_TL, 32'hffff_ffff);
        send_access(1, OFF_TX_TL, 32'h3);
        send_access(0, OFF_PARAM, 0);
        send_access(0, OFF_COMP_VER, 0);
        send_access(0, OFF_COMP_TYP, 0);
        send_access(0, 12'h0fd, 0);
        send_access(1, 12'hfff, 32'hffff_ffff, 1, 1, 8'hff, 4'hf);
        send_access(0, 12'h000, 0, 1, 1, 8'h00, 4'h8);
        send_access(1, OFF_ENABLE, 32'h0);
        send_access(0, OFF_CMD, 0);
        send_access(0, OFF_CLR_ALL, 0);
        drain();
        for (int n = 0; n < 1300; n++) begin
            if (n == 650) drain();
            if ($urandom_range(0, 40) == 0) begin
                send_access(1, OFF_ENABLE, $urandom_range(0, 7));
            end else begin
                r = '0;
                r.rx_byte = 8'($urandom());
                r.wdata = $urandom();
                r.offset = pick_offset();
                r.access_size = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : 4'd4;
                r.mode = 1'($urandom_range(0, 1));
                r.addr_ack = $urandom_range(0, 7) != 0;
                r.data_ack = $urandom_range(0, 7) != 0;
                if (r.offset == OFF_CMD && r.mode) r.wdata[31:11] = $urandom_range(0, 3) == 0
                    ? r.wdata[31:11] : '0;
                if (r.offset == 12'h04 && r.mode) r.wdata[31:3] = $urandom_range(0, 1)
                    ? r.wdata[31:3] : '0;
                send_access(r.mode, r.offset, r.wdata, r.addr_ack, r.data_ack, r.rx_byte,
                            r.access_size);
            end
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== i2c_master_register_block_unit.f =====
sv/i2cm_pkg.sv
sv/i2cm_ctrl.sv
sv/i2cm_dp.sv
sv/i2c_master_register_block_unit.sv
tb/tb_top.sv
